// ===== src/ile_pkg.sv =====
package ile_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned WordW       = 32;

  typedef enum logic [3:0] {
    FN_INS_FRONT = 4'd0,
    FN_INS_END   = 4'd1,
    FN_INS_AT    = 4'd2,
    FN_DEL_FRONT = 4'd3,
    FN_DEL_END   = 4'd4,
    FN_DEL_AT    = 4'd5,
    FN_UPDATE    = 4'd6,
    FN_SEARCH    = 4'd7,
    FN_CLEAR     = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_WR,
    CELL_ROT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [3:0]        func;
    logic [6:0]        index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] position;
    logic [6:0] length;
  } out_item_t;

  typedef struct packed {
    cell_op_e          op;
    logic [WordW-1:0]  word;
  } cell_cmd_t;

endpackage

// ===== src/ile_cell.sv =====
module ile_cell
  import ile_pkg::*;
#(
  parameter int unsigned Idx = 0,
  parameter int unsigned PosW = 7
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [PosW-1:0]  pos_i,
  input  logic [WordW-1:0] left_i,
  input  logic [WordW-1:0] right_i,
  output logic [WordW-1:0] data_o
);

  logic [WordW-1:0] data_q, data_d;
  logic             at_pos, past_pos;

  assign at_pos   = (pos_i == PosW'(Idx));
  assign past_pos = (PosW'(Idx) > pos_i);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (past_pos) begin
          data_d = left_i;
        end else if (at_pos) begin
          data_d = cmd_i.word;
        end
      end
      CELL_DEL: begin
        if (past_pos || at_pos) begin
          data_d = right_i;
        end
      end
      CELL_WR: begin
        if (at_pos) begin
          data_d = cmd_i.word;
        end
      end
      CELL_ROT: data_d = right_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== src/indexed_list_engine.sv =====
// indexed_list_engine: bounded ordered list of signed 32-bit words held in a
// chain of Capacity cells, one word per cell, cell 0 at the front. insert,
// delete and update shift or write every cell in parallel and finish in the
// cycle the item is accepted, so those items can be taken one per cycle.
// search rotates the whole chain once through cell 0, comparing the front
// word against the key each cycle, so a search item holds the input until
// the whole rotation is done and longer while the result is stalled
// (the rotation leaves the list as it was). one result item per input item,
// held in an output register; a new item is taken only while that register
// is free or being drained. the cell contents need no reset: only words
// below the length are ever read.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // count width, and a compare width that also covers the 7-bit index
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > 7) ? CntW : 7;

  state_e state_q, state_d;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  scan_q, scan_d;       // rotations done so far
  logic             hit_q, hit_d;
  logic [CntW-1:0]  hit_pos_q, hit_pos_d;
  logic [WordW-1:0] key_q, key_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      load_out;

  cell_cmd_t       cmd;
  logic [CntW-1:0] pos;
  logic [WordW-1:0] cell_data [Capacity];

  logic            accept, out_free, full, empty, is_search, scan_done;
  logic [CmpW-1:0] idx_x, cnt_x;

  function automatic logic [6:0] length_x(input logic [CntW-1:0] c);
    logic [CmpW-1:0] w;
    w = CmpW'(c);
    return w[6:0];
  endfunction

  function automatic logic [5:0] hit_pos_x(input logic [CntW-1:0] p);
    logic [CmpW-1:0] w;
    w = CmpW'(p);
    return w[5:0];
  endfunction

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_search  = (in_item_i.func == FN_SEARCH);
  assign full       = (count_q == CntW'(Capacity));
  assign empty      = (count_q == '0);
  assign idx_x      = CmpW'(in_item_i.index);
  assign cnt_x      = CmpW'(count_q);
  assign scan_done  = (scan_q == CntW'(Capacity));

  // the cell chain: each cell sees its front and back neighbor, cell 0 the
  // new word in front; the last cell wraps to cell 0 so a rotation keeps every word
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [WordW-1:0] left, right;
    if (g == 0) begin : g_front
      assign left = cmd.word;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_back
      assign right = cell_data[0];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    ile_cell #(
      .Idx  (g),
      .PosW (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_search) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.word  = in_item_i.value;
    pos       = '0;
    count_d   = count_q;
    scan_d    = scan_q;
    hit_d     = hit_q;
    hit_pos_d = hit_pos_q;
    key_d     = key_q;
    load_out  = 1'b0;
    out_d     = out_q;
    out_d.status   = STAT_OK;
    out_d.found    = 1'b0;
    out_d.position = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load_out = ~is_search;
          case (in_item_i.func)
            FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
              if (full) begin
                out_d.status = STAT_FULL;
              end else if ((in_item_i.func == FN_INS_AT) && (idx_x > cnt_x)) begin
                out_d.status = STAT_RANGE;
              end else begin
                cmd.op  = CELL_INS;
                count_d = count_q + 1'b1;
                if (in_item_i.func == FN_INS_END) begin
                  pos = count_q;
                end else if (in_item_i.func == FN_INS_AT) begin
                  pos = idx_x[CntW-1:0];
                end
              end
            end
            FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT, FN_UPDATE: begin
              if (empty) begin
                out_d.status = STAT_EMPTY;
              end else if (((in_item_i.func == FN_DEL_AT) || (in_item_i.func == FN_UPDATE))
                           && (idx_x >= cnt_x)) begin
                out_d.status = STAT_RANGE;
              end else if (in_item_i.func == FN_UPDATE) begin
                cmd.op = CELL_WR;
                pos    = idx_x[CntW-1:0];
              end else begin
                // deleting the back needs no shift
                count_d = count_q - 1'b1;
                if (in_item_i.func == FN_DEL_FRONT) begin
                  cmd.op = CELL_DEL;
                end else if (in_item_i.func == FN_DEL_AT) begin
                  cmd.op = CELL_DEL;
                  pos    = idx_x[CntW-1:0];
                end
              end
            end
            FN_SEARCH: begin
              key_d     = in_item_i.value;
              scan_d    = '0;
              hit_d     = 1'b0;
              hit_pos_d = '0;
            end
            FN_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          // front cell holds the word at position scan_q
          cmd.op = CELL_ROT;
          scan_d = scan_q + 1'b1;
          if (!hit_q && (scan_q < count_q) && (cell_data[0] == key_q)) begin
            hit_d     = 1'b1;
            hit_pos_d = scan_q;
          end
        end else if (out_free) begin
          load_out       = 1'b1;
          out_d.found    = hit_q;
          out_d.position = hit_pos_x(hit_pos_q);
        end
      end
      default: ;
    endcase

    out_d.length = length_x(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_pos_q <= hit_pos_d;
    key_q     <= key_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== dv/list_result_checker.sv =====
module list_result_checker
  import ile_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        errors_o,
  output int        pending_o,
  output int        results_o,
  output int        hits_o,
  output int        full_o,
  output int        empty_o,
  output int        range_o
);

  logic [WordW-1:0] words_q [Capacity];
  int unsigned      len_q;
  out_item_t        expected_q [$];

  function automatic void open_slot(input int unsigned pos, input logic [WordW-1:0] w);
    int unsigned k;
    for (k = len_q; k > pos; k--) begin
      words_q[k] = words_q[k-1];
    end
    words_q[pos] = w;
    len_q++;
  endfunction

  function automatic void close_slot(input int unsigned pos);
    int unsigned k;
    for (k = pos; k + 1 < len_q; k++) begin
      words_q[k] = words_q[k+1];
    end
    len_q--;
  endfunction

  // applies one item to the list copy and returns the result it should give
  function automatic out_item_t apply_list_op(input in_item_t it);
    out_item_t   r;
    int unsigned k;
    r = '0;
    r.status = STAT_OK;
    case (it.func)
      FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
        if (len_q >= Capacity) r.status = STAT_FULL;
        else if (it.func == FN_INS_FRONT) open_slot(0, it.value);
        else if (it.func == FN_INS_END) open_slot(len_q, it.value);
        else if (it.index > len_q) r.status = STAT_RANGE;
        else open_slot(it.index, it.value);
      end
      FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
        if (len_q == 0) r.status = STAT_EMPTY;
        else if (it.func == FN_DEL_FRONT) close_slot(0);
        else if (it.func == FN_DEL_END) close_slot(len_q - 1);
        else if (it.index >= len_q) r.status = STAT_RANGE;
        else close_slot(it.index);
      end
      FN_UPDATE: begin
        if (len_q == 0) r.status = STAT_EMPTY;
        else if (it.index >= len_q) r.status = STAT_RANGE;
        else words_q[it.index] = it.value;
      end
      FN_SEARCH: begin
        for (k = 0; k < len_q; k++) begin
          if (words_q[k] == it.value) begin
            r.found    = 1'b1;
            r.position = 6'(k);
            break;
          end
        end
      end
      FN_CLEAR: len_q = 0;
      default: ;
    endcase
    r.length = 7'(len_q);
    return r;
  endfunction

  function automatic void flag(input string what);
    errors_o++;
    if (errors_o <= 10) $display("%0t list mismatch: %s", $time, what);
  endfunction

  // check the leaving item first, then queue the arriving one: the result
  // register lies between them, so a same-edge pair never matches
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      len_q = 0;
      expected_q.delete();
      errors_o  = 0;
      pending_o = 0;
      results_o = 0;
      hits_o    = 0;
      full_o    = 0;
      empty_o   = 0;
      range_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          flag($sformatf("result %p with nothing expected", out_item_i));
        end else begin
          want = expected_q.pop_front();
          if (out_item_i.status !== want.status || out_item_i.found !== want.found ||
              out_item_i.position !== want.position || out_item_i.length !== want.length) begin
            flag($sformatf("status %0d/%0d found %0d/%0d position %0d/%0d length %0d/%0d",
                           want.status, out_item_i.status, want.found, out_item_i.found,
                           want.position, out_item_i.position, want.length,
                           out_item_i.length));
          end
          if (want.found) hits_o++;
          if (want.status == STAT_FULL) full_o++;
          if (want.status == STAT_EMPTY) empty_o++;
          if (want.status == STAT_RANGE) range_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_list_op(in_item_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import ile_pkg::*;

  localparam int unsigned Capacity    = CapacityDef;
  localparam int unsigned RandItems   = 500;
  localparam int unsigned CalmItems   = 80;    // tail of the run without idling
  localparam int unsigned HoldAt      = 100;   // random item that starts the long hold
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = Capacity + 20;  // a search keeps the block busy

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int errors, pending, results, hits, fulls, empties, ranges;

  // shared between the item driver and the result receiver
  bit          calm;
  bit          hold_req;
  bit          hold_done;
  int unsigned stall_cycles;
  int unsigned gap_window;
  bit          gaps_on;

  logic [WordW-1:0] pool [8] = '{32'h0, 32'hffff_ffff, 32'h1, 32'h7fff_ffff,
                                 32'h8000_0000, 32'd42, 32'hffff_ffd6, 32'h5a5a_5a5a};

  indexed_list_engine #(.Capacity(Capacity)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  list_result_checker #(.Capacity(Capacity)) u_list_result_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .hits_o     (hits),
    .full_o     (fulls),
    .empty_o    (empties),
    .range_o    (ranges)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // present one item and hold it until the block takes it; an optional
  // burst of idle cycles goes in front of it
  task automatic offer(input in_item_t it);
    int unsigned gap;
    if (gap_window == 0) begin
      gap_window = $urandom_range(10, 60);
      gaps_on    = 1'($urandom_range(0, 1));
    end
    gap_window--;
    if (gaps_on && !calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(posedge clk);
      if (in_stall) stall_cycles++;
    end while (in_stall);
  endtask

  task automatic offer_op(input logic [3:0] fn, input logic [6:0] idx,
                          input logic [WordW-1:0] val);
    in_item_t it;
    it.func  = fn;
    it.index = idx;
    it.value = val;
    offer(it);
  endtask

  // random item whose operation mix follows the phase of the run:
  // fill the list up to full, churn it, drain it to empty, fill again, churn
  function automatic in_item_t draw_op(input int unsigned n);
    in_item_t    it;
    int unsigned r;
    int unsigned pick;
    r = $urandom_range(0, 99);
    if (n < 150 || (n >= 250 + 100 && n < 450)) begin
      // fill phase
      if (r < 80) it.func = 4'(FN_INS_FRONT) + 4'($urandom_range(0, 2));
      else if (r < 90) it.func = FN_SEARCH;
      else it.func = 4'(FN_DEL_FRONT) + 4'($urandom_range(0, 3));
    end else if (n >= 250 && n < 350) begin
      // drain phase
      if (r < 70) it.func = 4'(FN_DEL_FRONT) + 4'($urandom_range(0, 2));
      else if (r < 85) it.func = FN_SEARCH;
      else it.func = 4'(FN_INS_FRONT) + 4'($urandom_range(0, 2));
    end else begin
      // churn: every code, unused ones included
      if (r < 1) it.func = FN_CLEAR;
      else if (r < 5) it.func = 4'(FN_CLEAR) + 4'($urandom_range(1, 7));
      else if (r < 40) it.func = 4'(FN_INS_FRONT) + 4'($urandom_range(0, 2));
      else if (r < 70) it.func = 4'(FN_DEL_FRONT) + 4'($urandom_range(0, 2));
      else if (r < 82) it.func = FN_UPDATE;
      else it.func = FN_SEARCH;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) it.index = 7'($urandom_range(0, 7));
    else if (pick < 85) it.index = 7'($urandom_range(0, Capacity));
    else it.index = 7'($urandom);
    // values half the time from a small pool so searches hit and duplicates occur
    if ($urandom_range(0, 1) == 0) it.value = pool[$urandom_range(0, 7)];
    else it.value = $urandom;
    return it;
  endfunction

  // result receiver: random stall bursts, one long hold-off to back up
  // the block, no stalls in the calm tail
  initial begin
    int unsigned burst;
    int unsigned window;
    bit          stall_on;
    out_stall <= 1'b0;
    window   = 0;
    stall_on = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (window == 0) begin
          window   = $urandom_range(20, 150);
          stall_on = 1'($urandom_range(0, 1));
        end
        window--;
        if (stall_on && !calm && $urandom_range(0, 4) == 0) begin
          burst = $urandom_range(1, 7);
          out_stall <= 1'b1;
          repeat (burst) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clear, search, every delete, update and indexed inserts on an empty list
    offer_op(FN_CLEAR, 7'd0, 32'h0);
    offer_op(FN_SEARCH, 7'd0, 32'h0);
    offer_op(FN_DEL_FRONT, 7'd0, 32'h0);
    offer_op(FN_DEL_END, 7'd0, 32'h0);
    offer_op(FN_DEL_AT, 7'd0, 32'h0);
    offer_op(FN_UPDATE, 7'd0, 32'h0);
    offer_op(FN_INS_AT, 7'd1, 32'h0);            // above length
    offer_op(FN_INS_AT, 7'd0, 32'h7fff_ffff);    // index zero goes to the front
    offer_op(FN_DEL_FRONT, 7'd0, 32'h0);         // removes the only element
    // build a short list with the extreme words
    offer_op(FN_INS_END, 7'd0, 32'h8000_0000);
    offer_op(FN_INS_FRONT, 7'd0, 32'hffff_ffff);
    offer_op(FN_INS_AT, 7'd2, 32'h0);            // index equal to length appends
    offer_op(FN_INS_AT, 7'h7f, 32'h0);
    offer_op(FN_INS_AT, 7'd1, 32'd5);
    offer_op(FN_UPDATE, 7'd3, 32'hffff_ffff);
    offer_op(FN_UPDATE, 7'd4, 32'h1);            // index equal to length
    offer_op(FN_UPDATE, 7'h7f, 32'h1);
    offer_op(FN_SEARCH, 7'd0, 32'hffff_ffff);    // two matches, first one wins
    offer_op(FN_SEARCH, 7'd0, 32'd12345);
    offer_op(FN_DEL_AT, 7'd4, 32'h0);
    offer_op(FN_DEL_AT, 7'h7f, 32'h0);
    offer_op(FN_DEL_AT, 7'd1, 32'h0);
    offer_op(FN_DEL_END, 7'd0, 32'h0);
    offer_op(4'(FN_CLEAR) + 4'd1, 7'h55, 32'h0);  // unused codes do nothing
    offer_op(4'(FN_CLEAR) + 4'd7, 7'h2a, 32'hffff_ffff);
    offer_op(FN_CLEAR, 7'd0, 32'h0);

    for (n = 0; n < RandItems; n++) begin
      if (n == HoldAt) hold_req = 1'b1;
      if (n >= RandItems - CalmItems) calm = 1'b1;
      offer(draw_op(n));
    end
    in_valid <= 1'b0;

    // let the checker see the last item before waiting on the drain
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("checked %0d results: %0d search hits, %0d full, %0d empty, %0d out of range",
             results, hits, fulls, empties, ranges);
    $display("input held off for %0d cycles, %0d mismatches, %0d still expected",
             stall_cycles, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ile_pkg.sv
src/ile_cell.sv
src/indexed_list_engine.sv
dv/list_result_checker.sv
dv/testbench.sv
